>>> rtl/sprb_pkg.sv
// ----------------------------------------------------------------------------
// sprb_pkg
// Shared types, codes and defaults of the sequenced packet reorder buffer.
// ----------------------------------------------------------------------------
package sprb_pkg;

  localparam int unsigned WindowSlotsDef = 16;
  localparam int unsigned HandleBitsDef  = 16;

  // action codes
  localparam logic [1:0] ACT_STORE = 2'd0;
  localparam logic [1:0] ACT_TAKE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // kind codes
  localparam logic [1:0] KIND_BAD = 2'd3;

  // slot tags
  localparam logic [1:0] TAG_WAIT  = 2'd0;
  localparam logic [1:0] TAG_WHOLE = 2'd1;
  localparam logic [1:0] TAG_FRAG  = 2'd2;
  localparam logic [1:0] TAG_TAIL  = 2'd3;

  // result status codes
  localparam logic [3:0] ST_STORED   = 4'd0;
  localparam logic [3:0] ST_OLD      = 4'd1;
  localparam logic [3:0] ST_DUP      = 4'd2;
  localparam logic [3:0] ST_BEYOND   = 4'd3;
  localparam logic [3:0] ST_BADKIND  = 4'd4;
  localparam logic [3:0] ST_NONE     = 4'd5;
  localparam logic [3:0] ST_RELEASED = 4'd6;
  localparam logic [3:0] ST_TAILHEAD = 4'd7;
  localparam logic [3:0] ST_BROKEN   = 4'd8;

  typedef enum logic [1:0] {
    RD_STORE = 2'd0,
    RD_SCAN  = 2'd1,
    RD_HEAD  = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_CLEAR  = 2'd1,
    WR_STORE  = 2'd2,
    WR_RETIRE = 2'd3
  } wr_sel_e;

  typedef struct packed {
    logic       load_in;
    logic       head_reset;
    logic       head_adv;
    logic       idx_clr;
    logic       idx_inc;
    logic       len_set;
    logic       len_dec;
    logic       rd_en;
    rd_sel_e    rd_sel;
    wr_sel_e    wr_sel;
    logic       out_load;
    logic [3:0] out_code;
    logic       out_rel;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic       old;
    logic       beyond;
    logic       kind_bad;
    logic [1:0] rd_tag;
    logic       idx_zero;
    logic       idx_last;
    logic       len_one;
    logic       out_free;
  } stat_t;

endpackage

>>> rtl/sprb_ctrl.sv
// ----------------------------------------------------------------------------
// sprb_ctrl
// Sequencer: clear sweep, store check, chain scan and in-order release.
// ----------------------------------------------------------------------------
module sprb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_action_i,
  output logic               in_ready_o,
  input  sprb_pkg::stat_t    stat_i,
  output sprb_pkg::cmd_t     cmd_o
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ST_RD = 8'b0000_0100,
    S_ST_EV = 8'b0000_1000,
    S_SC_RD = 8'b0001_0000,
    S_SC_EV = 8'b0010_0000,
    S_RL_RD = 8'b0100_0000,
    S_RL_EV = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic       sc_emit;
  logic [3:0] sc_code;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.rd_sel  = sprb_pkg::RD_STORE;
    cmd_o.wr_sel  = sprb_pkg::WR_NONE;
    in_ready_o    = 1'b0;
    sc_emit       = 1'b0;
    sc_code       = sprb_pkg::ST_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.head_reset = 1'b1;
        cmd_o.wr_sel     = sprb_pkg::WR_CLEAR;
        if (stat_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          case (in_action_i)
            sprb_pkg::ACT_STORE: state_d = S_ST_RD;
            sprb_pkg::ACT_TAKE: begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_SC_RD;
            end
            sprb_pkg::ACT_CLEAR: begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_ST_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = sprb_pkg::RD_STORE;
        state_d      = S_ST_EV;
      end
      S_ST_EV: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          if (stat_i.old) begin
            cmd_o.out_code = sprb_pkg::ST_OLD;
          end else if (stat_i.beyond) begin
            cmd_o.out_code = sprb_pkg::ST_BEYOND;
          end else if (stat_i.rd_tag != sprb_pkg::TAG_WAIT) begin
            cmd_o.out_code = sprb_pkg::ST_DUP;
          end else if (stat_i.kind_bad) begin
            cmd_o.out_code = sprb_pkg::ST_BADKIND;
          end else begin
            cmd_o.out_code = sprb_pkg::ST_STORED;
            cmd_o.wr_sel   = sprb_pkg::WR_STORE;
          end
          state_d = S_IDLE;
        end
      end
      S_SC_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = sprb_pkg::RD_SCAN;
        state_d      = S_SC_EV;
      end
      S_SC_EV: begin
        case (stat_i.rd_tag)
          sprb_pkg::TAG_WAIT: begin
            sc_emit = 1'b1;
            sc_code = sprb_pkg::ST_NONE;
          end
          sprb_pkg::TAG_TAIL: begin
            if (stat_i.idx_zero) begin
              sc_emit = 1'b1;
              sc_code = sprb_pkg::ST_TAILHEAD;
            end else begin
              cmd_o.len_set = 1'b1;
              state_d       = S_RL_RD;
            end
          end
          sprb_pkg::TAG_WHOLE: begin
            if (stat_i.idx_zero) begin
              cmd_o.len_set = 1'b1;
              state_d       = S_RL_RD;
            end else begin
              sc_emit = 1'b1;
              sc_code = sprb_pkg::ST_BROKEN;
            end
          end
          default: begin
            // fragment: a chain that fills the window never completes
            if (stat_i.idx_last) begin
              sc_emit = 1'b1;
              sc_code = sprb_pkg::ST_BROKEN;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d       = S_SC_RD;
            end
          end
        endcase
        if (sc_emit && stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_code = sc_code;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_RL_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = sprb_pkg::RD_HEAD;
        state_d      = S_RL_EV;
      end
      S_RL_EV: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_code = sprb_pkg::ST_RELEASED;
          cmd_o.out_rel  = 1'b1;
          cmd_o.out_last = stat_i.len_one;
          cmd_o.wr_sel   = sprb_pkg::WR_RETIRE;
          cmd_o.head_adv = 1'b1;
          cmd_o.len_dec  = 1'b1;
          state_d        = stat_i.len_one ? S_IDLE : S_RL_RD;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result loaded while output register busy");

  a_store_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_sel == sprb_pkg::WR_STORE) |->
      (stat_i.rd_tag == sprb_pkg::TAG_WAIT && !stat_i.old && !stat_i.beyond
       && !stat_i.kind_bad))
    else $error("slot written by a rejected store");

endmodule

>>> rtl/sprb_dpath.sv
// ----------------------------------------------------------------------------
// sprb_dpath
// Slot memory, head pointers, scan counters and the output register.
// ----------------------------------------------------------------------------
module sprb_dpath #(
  parameter int unsigned WINDOW_SLOTS = sprb_pkg::WindowSlotsDef,
  parameter int unsigned HANDLE_BITS  = sprb_pkg::HandleBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      in_ordinal_i,
  input  logic [1:0]       in_kind_i,
  input  logic [15:0]      in_handle_i,
  input  sprb_pkg::cmd_t   cmd_i,
  output sprb_pkg::stat_t  stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [3:0]       out_status_o,
  output logic [15:0]      out_handle_o,
  output logic [31:0]      out_ordinal_o,
  output logic             out_last_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int unsigned SUM_W  = SLOT_W + 1;
  localparam int unsigned LEN_W  = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned MEM_W  = HANDLE_BITS + 2;

  // slot word: tag in the top two bits, handle below
  logic [MEM_W-1:0]       mem_q [WINDOW_SLOTS];
  logic [MEM_W-1:0]       rdata_q;

  logic [31:0]            ord_q;
  logic [1:0]             kind_q;
  logic [HANDLE_BITS-1:0] hdl_q;
  logic [31:0]            head_ord_q, head_ord_d;
  logic [SLOT_W-1:0]      head_slot_q, head_slot_d;
  logic [SLOT_W-1:0]      idx_q, idx_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic                   out_valid_q;

  logic [31:0]            off;
  logic                   old, beyond;
  logic [SLOT_W-1:0]      store_slot, scan_slot, rd_addr, wr_addr;
  logic [MEM_W-1:0]       wr_data;
  logic                   wr_en;
  logic [1:0]             rd_tag;
  logic [HANDLE_BITS-1:0] rd_hdl;
  logic                   out_free;

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SUM_W'(WINDOW_SLOTS)) begin
      sum = sum - SUM_W'(WINDOW_SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  assign off        = ord_q - head_ord_q;
  assign old        = ord_q < head_ord_q;
  assign beyond     = off >= 32'(WINDOW_SLOTS);
  assign store_slot = beyond ? head_slot_q : slot_add(head_slot_q, off[SLOT_W-1:0]);
  assign scan_slot  = slot_add(head_slot_q, idx_q);
  assign rd_tag     = rdata_q[MEM_W-1 -: 2];
  assign rd_hdl     = rdata_q[HANDLE_BITS-1:0];
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.rd_sel)
      sprb_pkg::RD_SCAN: rd_addr = scan_slot;
      sprb_pkg::RD_HEAD: rd_addr = head_slot_q;
      default:           rd_addr = store_slot;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = head_slot_q;
    wr_data = {sprb_pkg::TAG_WAIT, HANDLE_BITS'(0)};
    case (cmd_i.wr_sel)
      sprb_pkg::WR_CLEAR: wr_addr = idx_q;
      sprb_pkg::WR_STORE: begin
        wr_addr = store_slot;
        // kinds 0..2 map onto tags whole, fragment, tail
        wr_data = {kind_q + 2'd1, hdl_q};
      end
      sprb_pkg::WR_RETIRE: wr_addr = head_slot_q;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ord_q  <= in_ordinal_i;
      kind_q <= in_kind_i;
      hdl_q  <= HANDLE_BITS'(in_handle_i);
    end
    if (cmd_i.out_load) begin
      out_status_o  <= cmd_i.out_code;
      out_handle_o  <= cmd_i.out_rel ? 16'(rd_hdl) : 16'd0;
      out_ordinal_o <= cmd_i.out_rel ? head_ord_q : 32'd0;
      out_last_o    <= cmd_i.out_last;
    end
  end

  always_comb begin
    head_ord_d  = head_ord_q;
    head_slot_d = head_slot_q;
    if (cmd_i.head_reset) begin
      head_ord_d  = 32'd1;
      head_slot_d = '0;
    end else if (cmd_i.head_adv) begin
      head_ord_d  = head_ord_q + 32'd1;
      head_slot_d = slot_add(head_slot_q, SLOT_W'(1));
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + SLOT_W'(1);
    end
    len_d = len_q;
    if (cmd_i.len_set) begin
      len_d = LEN_W'(idx_q) + LEN_W'(1);
    end else if (cmd_i.len_dec) begin
      len_d = len_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ord_q  <= 32'd1;
      head_slot_q <= '0;
      idx_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_ord_q  <= head_ord_d;
      head_slot_q <= head_slot_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.old      = old;
  assign stat_o.beyond   = beyond;
  assign stat_o.kind_bad = kind_q == sprb_pkg::KIND_BAD;
  assign stat_o.rd_tag   = rd_tag;
  assign stat_o.idx_zero = idx_q == '0;
  assign stat_o.idx_last = idx_q == SLOT_W'(WINDOW_SLOTS - 1);
  assign stat_o.len_one  = len_q == LEN_W'(1);
  assign stat_o.out_free = out_free;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, head_slot_q} < SUM_W'(WINDOW_SLOTS)) && ({1'b0, idx_q} < SUM_W'(WINDOW_SLOTS)))
    else $error("slot pointer outside the window");

  a_len_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.len_dec |-> len_q != '0)
    else $error("release beat with no fragments left");

  a_rel_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && cmd_i.out_rel) |-> rd_tag != sprb_pkg::TAG_WAIT)
    else $error("released an empty slot");

endmodule

>>> rtl/sequenced_packet_reorder_buffer.sv
// ----------------------------------------------------------------------------
// sequenced_packet_reorder_buffer
// Receive reorder window keyed by packet ordinal, releasing packets and
// complete fragment chains in order.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata (low bit up)                   tuser (low bit up)  tlast
//  s_axis   in   ordinal[31:0], payload_handle[15:0]  action[1:0], kind   -
//  m_axis   out  released_handle[15:0], ordinal[31:0] status[3:0]         last
//
//  Store: accept, slot read, check/write.
//  Take: accept, then a slot read and an evaluation for each slot scanned and
//  for each released beat; each slot read has its own state before its check.
//  Clear: accept, then a sweep that writes every slot. After reset the same
//  sweep clears the slot memory before s_axis_tready rises.
//  A result waiting in the output register does not block the next accept;
//  a stalled m_axis holds the sequencer in its result state.
// ----------------------------------------------------------------------------
module sequenced_packet_reorder_buffer #(
  parameter int unsigned WINDOW_SLOTS = sprb_pkg::WindowSlotsDef,
  parameter int unsigned HANDLE_BITS  = sprb_pkg::HandleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // ordinal[31:0], payload_handle[47:32]
  input  logic [3:0]  s_axis_tuser,   // action[1:0], kind[3:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // released_handle[15:0], released_ordinal[47:16]
  output logic [3:0]  m_axis_tuser,   // status[3:0]
  output logic        m_axis_tlast
);

  sprb_pkg::cmd_t  cmd;
  sprb_pkg::stat_t stat;
  logic [15:0]     out_handle;
  logic [31:0]     out_ordinal;

  sprb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[1:0]),
    .in_ready_o  (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sprb_dpath #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .HANDLE_BITS  (HANDLE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ordinal_i  (s_axis_tdata[31:0]),
    .in_kind_i     (s_axis_tuser[3:2]),
    .in_handle_i   (s_axis_tdata[47:32]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (m_axis_tuser),
    .out_handle_o  (out_handle),
    .out_ordinal_o (out_ordinal),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {out_ordinal, out_handle};

endmodule

>>> tb/sv/sprb_order_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprb_order_monitor
// Watches both streams of the reorder buffer. It keeps its own copy of the
// window to predict every result beat and compares result beats in order.
// ----------------------------------------------------------------------------
module sprb_order_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // ordinal[31:0], payload_handle[47:32]
  input  logic [3:0]  s_axis_tuser,   // action[1:0], kind[3:2]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // released_handle[15:0], released_ordinal[47:16]
  input  logic [3:0]  m_axis_tuser,   // status[3:0]
  input  logic        m_axis_tlast,
  output int          errors_o,
  output int          open_o,
  output int          checked_o
);
  import sprb_pkg::*;

  localparam int unsigned SLOTS = WindowSlotsDef;
  localparam int unsigned IDX_W = $clog2(SLOTS);

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] handle;
    logic [31:0] ordinal;
    logic        last;
  } rel_beat_t;

  rel_beat_t        due_q[$];
  logic [1:0]       slot_tag [SLOTS];
  logic [15:0]      slot_hdl [SLOTS];
  logic [31:0]      head_ord;
  logic [IDX_W-1:0] head_idx;
  int               mismatches = 0;
  int               compared = 0;

  assign errors_o  = mismatches;
  assign checked_o = compared;

  task automatic log_mismatch(input string what);
    $display("[%0t] result beat %0d: %s", $time, compared, what);
    mismatches++;
  endtask

  task automatic due(input logic [3:0] status, input logic [15:0] handle,
                     input logic [31:0] ordinal, input logic last);
    rel_beat_t b;
    b.status  = status;
    b.handle  = handle;
    b.ordinal = ordinal;
    b.last    = last;
    due_q.insert(due_q.size(), b);
  endtask

  task automatic empty_window();
    for (int i = 0; i < SLOTS; i++) begin
      slot_tag[i] = TAG_WAIT;
    end
    head_ord = 32'd1;
    head_idx = '0;
  endtask

  task automatic predict(input logic [1:0] act, input logic [31:0] ord,
                         input logic [1:0] knd, input logic [15:0] hdl);
    logic [31:0]      off;
    logic [IDX_W-1:0] at;
    logic [1:0]       t;
    logic [3:0]       code;
    int               len;
    case (act)
      ACT_STORE: begin
        off = ord - head_ord;
        at  = head_idx + off[IDX_W-1:0];
        if (ord < head_ord) begin
          due(ST_OLD, '0, '0, 1'b1);
        end else if (off >= SLOTS) begin
          due(ST_BEYOND, '0, '0, 1'b1);
        end else if (slot_tag[at] != TAG_WAIT) begin
          due(ST_DUP, '0, '0, 1'b1);
        end else if (knd == KIND_BAD) begin
          due(ST_BADKIND, '0, '0, 1'b1);
        end else begin
          slot_hdl[at] = hdl;
          slot_tag[at] = knd + 2'd1;  // tag codes are the kind codes shifted up by one
          due(ST_STORED, '0, '0, 1'b1);
        end
      end
      ACT_TAKE: begin
        len  = 0;
        code = ST_BROKEN;  // a window full of fragments never completes
        t    = slot_tag[head_idx];
        if (t == TAG_WAIT) begin
          code = ST_NONE;
        end else if (t == TAG_TAIL) begin
          code = ST_TAILHEAD;
        end else if (t == TAG_WHOLE) begin
          len = 1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            at = head_idx + IDX_W'(i);
            t  = slot_tag[at];
            if (t == TAG_WAIT) begin
              code = ST_NONE;
              break;
            end
            if (t == TAG_WHOLE) begin
              code = ST_BROKEN;
              break;
            end
            if (t == TAG_TAIL) begin
              len = i + 1;
              break;
            end
          end
        end
        if (len == 0) begin
          due(code, '0, '0, 1'b1);
        end
        for (int i = 0; i < len; i++) begin
          due(ST_RELEASED, slot_hdl[head_idx], head_ord, (i == len - 1));
          slot_tag[head_idx] = TAG_WAIT;
          head_idx = head_idx + 1'b1;
          head_ord = head_ord + 32'd1;
        end
      end
      ACT_CLEAR: empty_window();
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rel_beat_t want;
    rel_beat_t got;
    if (!rst_ni) begin
      empty_window();
      due_q.delete();
      open_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tuser;
        got.handle  = m_axis_tdata[15:0];
        got.ordinal = m_axis_tdata[47:16];
        got.last    = m_axis_tlast;
        if (due_q.size() == 0) begin
          log_mismatch($sformatf("unexpected, status %0d", got.status));
        end else begin
          want = due_q[0];
          due_q.delete(0);
          if (got.status != want.status)
            log_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.handle != want.handle)
            log_mismatch($sformatf("handle 0x%04h, expected 0x%04h",
                                   got.handle, want.handle));
          if (got.ordinal != want.ordinal)
            log_mismatch($sformatf("ordinal %0d, expected %0d", got.ordinal, want.ordinal));
          if (got.last != want.last)
            log_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
          compared++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict(s_axis_tuser[1:0], s_axis_tdata[31:0], s_axis_tuser[3:2],
                s_axis_tdata[47:32]);
      end
      open_o <= due_q.size();
    end
  end

endmodule

>>> tb/sv/tb_sequenced_packet_reorder_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequenced_packet_reorder_buffer
// Drives directed corner beats, then rounds of shuffled packets and fragment
// chains with noise and broken chains, under random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_sequenced_packet_reorder_buffer;
  import sprb_pkg::*;

  localparam logic [1:0] KIND_WHOLE = 2'd0;
  localparam logic [1:0] KIND_FRAG  = 2'd1;
  localparam logic [1:0] KIND_TAIL  = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;  // unused action, dropped by the block

  localparam int RANDOM_BEATS = 270;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // ordinal[31:0], payload_handle[47:32]
  logic [3:0]  s_axis_tuser = '0;   // action[1:0], kind[3:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // released_handle[15:0], released_ordinal[47:16]
  logic [3:0]  m_axis_tuser;        // status[3:0]
  logic        m_axis_tlast;

  int errors;
  int open_results;
  int checked;
  bit calm = 1'b0;
  int beats_sent = 0;

  sequenced_packet_reorder_buffer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sprb_order_monitor u_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors_o      (errors),
    .open_o        (open_results),
    .checked_o     (checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 21);
  end

  initial begin
    #10_000_000;
    $display("sequenced_packet_reorder_buffer regression: fail");
    $finish;
  end

  // Called at a clock edge; returns at the edge that accepts the beat.
  task automatic send_beat(input logic [1:0] act, input logic [31:0] ord,
                           input logic [1:0] knd, input logic [15:0] hdl);
    if (!calm) begin
      while ($urandom_range(99) < 21) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hdl, ord};
    s_axis_tuser  <= {knd, act};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act != ACT_NOP) beats_sent++;
  endtask

  task automatic put_pkt(input logic [31:0] ord, input logic [1:0] knd,
                         input logic [15:0] hdl);
    send_beat(ACT_STORE, ord, knd, hdl);
  endtask

  task automatic take_pkt();
    send_beat(ACT_TAKE, $urandom(), 2'($urandom_range(3)), 16'($urandom_range(65535)));
  endtask

  task automatic wipe();
    send_beat(ACT_CLEAR, $urandom(), 2'($urandom_range(3)), 16'($urandom_range(65535)));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (open_results != 0) @(posedge clk_i);
  endtask

  initial begin : stim
    logic [1:0]  kinds [16];
    logic [15:0] hdls [16];
    int          order [16];
    logic [31:0] base;
    int          n, mode, pos, len, units, j, k, tmp, ord_pick;
    int          rounds, odd_rounds, start_count;
    bit          broken;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    take_pkt();                                // empty window
    put_pkt(32'd0, KIND_WHOLE, 16'h1234);      // below head
    put_pkt(32'd17, KIND_WHOLE, 16'h0000);     // one past the window
    put_pkt(32'hFFFF_FFFF, KIND_TAIL, 16'hFFFF);
    put_pkt(32'd16, KIND_BAD, 16'hFFFF);       // bad kind on the last slot
    put_pkt(32'd16, KIND_WHOLE, 16'hFFFF);     // last slot of the window
    put_pkt(32'd1, KIND_WHOLE, 16'h0000);
    put_pkt(32'd1, KIND_FRAG, 16'h5555);       // duplicate
    send_beat(ACT_NOP, 32'hFFFF_FFFF, 2'd3, 16'hFFFF);
    take_pkt();                                // releases ordinal 1
    put_pkt(32'd1, KIND_WHOLE, 16'h0001);      // now stale
    put_pkt(32'd2, KIND_TAIL, 16'hAAAA);
    take_pkt();                                // tail sits at head
    wipe();
    put_pkt(32'd1, KIND_FRAG, 16'h0101);
    put_pkt(32'd3, KIND_TAIL, 16'h0303);
    take_pkt();                                // gap inside the chain
    put_pkt(32'd2, KIND_WHOLE, 16'h0202);
    take_pkt();                                // whole packet inside the chain
    wipe();
    put_pkt(32'd1, KIND_FRAG, 16'hA5A5);
    put_pkt(32'd2, KIND_TAIL, 16'h5A5A);
    take_pkt();                                // two-beat chain
    take_pkt();
    settle();                                  // hold off until all results are back

    wipe();
    base = 32'd1;
    rounds = 0;
    odd_rounds = 0;
    start_count = beats_sent;
    while (beats_sent - start_count < RANDOM_BEATS) begin
      calm = (rounds >= 8 && rounds < 14);
      n = ($urandom_range(9) == 0) ? 16 : $urandom_range(8, 1);
      mode = $urandom_range(99);
      broken = (mode < 12);
      units = 0;
      for (j = 0; j < n; j++) hdls[j] = 16'($urandom_range(65535));

      if (n == 16 && mode < 65) begin
        // one chain across the whole window, with or without its tail
        for (j = 0; j < 16; j++) kinds[j] = KIND_FRAG;
        broken = (mode >= 50);
        if (!broken) kinds[15] = KIND_TAIL;
        units = 1;
      end else begin
        pos = 0;
        while (pos < n) begin
          len = (pos == n - 1 || $urandom_range(2) == 0) ? 1 : $urandom_range(n - pos, 2);
          for (j = 0; j < len; j++) begin
            if (j < len - 1) kinds[pos + j] = KIND_FRAG;
            else kinds[pos + j] = (len == 1) ? KIND_WHOLE : KIND_TAIL;
          end
          units++;
          pos += len;
        end
        if (broken) kinds[$urandom_range(n - 1)] = 2'($urandom_range(2));
      end

      for (j = 0; j < n; j++) order[j] = j;
      for (j = n - 1; j > 0; j--) begin
        k = $urandom_range(j);
        tmp = order[j];
        order[j] = order[k];
        order[k] = tmp;
      end

      for (k = 0; k < n; k++) begin
        if ($urandom_range(99) < 18) begin
          case ($urandom_range(4))
            0: begin
              ord_pick = (k > 0) ? order[$urandom_range(k - 1)] : -1;
              put_pkt(base + ord_pick, 2'($urandom_range(3)), 16'($urandom_range(65535)));
            end
            1: put_pkt(base - 32'd1 - $urandom_range(base - 32'd1), 2'($urandom_range(3)),
                       16'($urandom_range(65535)));
            2: put_pkt($urandom(), 2'($urandom_range(3)), 16'($urandom_range(65535)));
            3: put_pkt(base + order[$urandom_range(n - 1, k)], KIND_BAD,
                       16'($urandom_range(65535)));
            default: send_beat(ACT_NOP, $urandom(), 2'($urandom_range(3)),
                               16'($urandom_range(65535)));
          endcase
        end
        put_pkt(base + order[k], kinds[order[k]], hdls[order[k]]);
        if ($urandom_range(99) < 25) take_pkt();
      end

      if (broken) begin
        for (j = 0; j < n; j++) take_pkt();
        wipe();
        base = 32'd1;
        odd_rounds++;
      end else begin
        for (j = 0; j <= units; j++) take_pkt();
        base = base + n;
        if ($urandom_range(9) == 0) begin
          wipe();
          base = 32'd1;
        end
      end
      if ($urandom_range(9) == 0) settle();
      rounds++;
    end

    calm = 1'b0;
    settle();
    repeat (40) @(posedge clk_i);

    $display("covered %0d input beats: directed corners plus %0d rounds, %0d of them broken",
             beats_sent, rounds, odd_rounds);
    $display("compared %0d result beats in order", checked);
    if (errors == 0) begin
      $display("sequenced_packet_reorder_buffer regression: pass");
    end else begin
      $display("sequenced_packet_reorder_buffer regression: fail");
    end
    $finish;
  end

endmodule
